/* src/dq_pkg.sv */
package dq_pkg;

    // queue size and derived widths
    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int OCC_W       = 5;
    localparam int DATA_W      = 32;

    // operation codes carried on the input beat
    typedef enum logic [1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_BACK  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_BACK   = 2'd3
    } dq_op_t;

    // status codes carried on the result beat
    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } dq_status_t;

    // command broadcast to every cell of the row
    typedef struct packed {
        logic             shift_in;   // push front: every cell takes its left neighbor
        logic             shift_out;  // pop front: every cell takes its right neighbor
        logic             load_back;  // push back: one cell takes the new value
        logic [IDX_W-1:0] back_idx;   // cell that receives the push-back value
    } dq_cell_cmd_t;

endpackage

/* src/dq_cell.sv */
module dq_cell (
    input  logic                        aclk,
    input  dq_pkg::dq_cell_cmd_t        cmd,
    input  logic [dq_pkg::IDX_W-1:0]    cell_idx,
    input  logic [dq_pkg::DATA_W-1:0]   new_value,
    input  logic [dq_pkg::DATA_W-1:0]   left_value,
    input  logic [dq_pkg::DATA_W-1:0]   right_value,
    output logic [dq_pkg::DATA_W-1:0]   slot_value
);
    import dq_pkg::*;

    logic [DATA_W-1:0] slot_reg;
    logic [DATA_W-1:0] slot_next;

    // pick the next content: shift toward the back, toward the front, or load at the back
    always_comb begin
        slot_next = slot_reg;
        if (cmd.shift_in) begin
            slot_next = left_value;
        end else if (cmd.shift_out) begin
            slot_next = right_value;
        end else if (cmd.load_back && (cmd.back_idx == cell_idx)) begin
            slot_next = new_value;
        end
    end

    // slot storage, no reset needed
    always_ff @(posedge aclk) begin
        slot_reg <= slot_next;
    end

    assign slot_value = slot_reg;

endmodule

/* src/double_ended_queue.sv */
// Bounded double-ended queue of 16 signed 32-bit values, built as a row of
// cells where index 0 is always the front. Each input beat is one operation
// (push front, push back, pop front, pop back, code on s_tuser, value on
// s_tdata) and gives exactly one result beat: status on m_tuser, and on
// m_tdata the popped value (zero for pushes and failed pops) and the
// occupancy after the operation. A pop on an empty queue reports underflow,
// a push on a full queue reports overflow and drops the value; neither
// changes the contents. The cell row shifts or loads on the clock edge that
// accepts the beat, and a new beat is taken in each cycle in which the result
// register is empty or its beat is being taken downstream.
module double_ended_queue (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic [1:0]  s_tuser,   // [1:0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] removed_value, [36:32] occupancy, [39:37] zero
    output logic [1:0]  m_tuser    // [1:0] status
);
    import dq_pkg::*;

    logic [OCC_W-1:0]  count_reg;
    logic [OCC_W-1:0]  count_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [1:0]        out_status_reg;
    logic [DATA_W-1:0] out_removed_reg;
    logic [OCC_W-1:0]  out_occ_reg;

    dq_op_t            op;
    logic [DATA_W-1:0] in_value;
    logic              accept;
    logic              is_full;
    logic              is_empty;
    dq_cell_cmd_t      cell_cmd;
    dq_status_t        status;
    logic [DATA_W-1:0] removed;
    logic [IDX_W-1:0]  back_read_idx;
    logic [DATA_W-1:0] slots [QUEUE_DEPTH];

    assign op       = dq_op_t'(s_tuser);
    assign in_value = s_tdata;
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign is_full  = (count_reg == OCC_W'(QUEUE_DEPTH));
    assign is_empty = (count_reg == '0);

    // last stored value sits one below the count, wrapping when full
    assign back_read_idx = count_reg[IDX_W-1:0] - IDX_W'(1);

    // decode the operation into a cell command, a status and the new count
    always_comb begin
        cell_cmd           = '0;
        cell_cmd.back_idx  = count_reg[IDX_W-1:0];
        status             = ST_DONE;
        removed            = '0;
        count_next         = count_reg;
        case (op)
            OP_PUSH_FRONT: begin
                if (is_full) begin
                    status = ST_OVERFLOW;
                end else begin
                    cell_cmd.shift_in = accept;
                    count_next        = count_reg + OCC_W'(1);
                end
            end
            OP_PUSH_BACK: begin
                if (is_full) begin
                    status = ST_OVERFLOW;
                end else begin
                    cell_cmd.load_back = accept;
                    count_next         = count_reg + OCC_W'(1);
                end
            end
            OP_POP_FRONT: begin
                if (is_empty) begin
                    status = ST_UNDERFLOW;
                end else begin
                    cell_cmd.shift_out = accept;
                    removed            = slots[0];
                    count_next         = count_reg - OCC_W'(1);
                end
            end
            OP_POP_BACK: begin
                if (is_empty) begin
                    status = ST_UNDERFLOW;
                end else begin
                    removed    = slots[back_read_idx];
                    count_next = count_reg - OCC_W'(1);
                end
            end
            default: begin
                status = ST_DONE;
            end
        endcase
    end

    // row of cells, front at index 0
    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        logic [DATA_W-1:0] left_value;
        logic [DATA_W-1:0] right_value;

        if (i == 0) begin : g_front
            assign left_value = in_value;
        end else begin : g_inner_l
            assign left_value = slots[i-1];
        end

        if (i == QUEUE_DEPTH - 1) begin : g_back
            assign right_value = '0;
        end else begin : g_inner_r
            assign right_value = slots[i+1];
        end

        dq_cell u_cell (
            .aclk        (aclk),
            .cmd         (cell_cmd),
            .cell_idx    (IDX_W'(i)),
            .new_value   (in_value),
            .left_value  (left_value),
            .right_value (right_value),
            .slot_value  (slots[i])
        );
    end

    // result beat handshake
    always_comb begin
        out_valid_next = out_valid_reg;
        if (accept) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (accept) begin
                count_reg <= count_next;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            out_status_reg  <= status;
            out_removed_reg <= removed;
            out_occ_reg     <= count_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {3'b000, out_occ_reg, out_removed_reg};

endmodule

/* sim/double_ended_queue_test.sv */
module double_ended_queue_test;
    import dq_pkg::*;

    localparam int ITEM_COUNT  = 1000;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_AFTER  = 300;
    localparam int HOLD_CYCLES = 80;
    localparam int SIDE_TX     = 0;
    localparam int SIDE_RX     = 1;

    typedef struct {
        dq_op_t            op;
        logic [DATA_W-1:0] value;
    } deque_op_t;

    typedef struct {
        dq_status_t        status;
        logic [DATA_W-1:0] removed;
        logic [OCC_W-1:0]  occupancy;
    } deque_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // [31:0] value
    logic [1:0]  s_tuser  = '0;   // [1:0] opcode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;         // [31:0] removed_value, [36:32] occupancy, [39:37] zero
    logic [1:0]  m_tuser;         // [1:0] status

    double_ended_queue u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    deque_op_t     pending_ops[$];
    deque_result_t expected_results[$];
    int            mismatches   = 0;
    int            results_seen = 0;
    int            cycles       = 0;
    bit            in_taken     = 1'b0;
    bit            out_taken    = 1'b0;

    // predictor copy of the deque
    logic [DATA_W-1:0] slot_copy [QUEUE_DEPTH];
    int                front_idx  = 0;
    int                back_idx   = 0;
    int                fill_count = 0;

    // idle pattern per side: runs of busy or calm beats
    int run_left [2] = '{0, 0};
    bit calm     [2] = '{1'b0, 1'b0};

    function automatic int draw_idle(input int side);
        if (run_left[side] == 0) begin
            run_left[side] = $urandom_range(8, 40);
            calm[side]     = ($urandom_range(0, 2) == 0);
        end
        run_left[side]--;
        return calm[side] ? 0 : $urandom_range(0, 4);
    endfunction

    // apply one operation to the deque copy and return its result beat
    function automatic deque_result_t deque_apply(input dq_op_t op, input logic [DATA_W-1:0] val);
        deque_result_t r;
        r.status  = ST_DONE;
        r.removed = '0;
        if (op == OP_PUSH_FRONT || op == OP_PUSH_BACK) begin
            if (fill_count >= QUEUE_DEPTH) begin
                r.status = ST_OVERFLOW;
            end else if (op == OP_PUSH_FRONT) begin
                front_idx = (front_idx + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
                slot_copy[front_idx] = val;
                fill_count++;
            end else begin
                slot_copy[back_idx] = val;
                back_idx = (back_idx + 1) % QUEUE_DEPTH;
                fill_count++;
            end
        end else begin
            if (fill_count == 0) begin
                r.status = ST_UNDERFLOW;
            end else if (op == OP_POP_FRONT) begin
                r.removed = slot_copy[front_idx];
                front_idx = (front_idx + 1) % QUEUE_DEPTH;
                fill_count--;
            end else begin
                back_idx  = (back_idx + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
                r.removed = slot_copy[back_idx];
                fill_count--;
            end
        end
        r.occupancy = fill_count[OCC_W-1:0];
        return r;
    endfunction

    function automatic void add_op(input dq_op_t op, input logic [DATA_W-1:0] val);
        deque_op_t it;
        it.op    = op;
        it.value = val;
        pending_ops.insert(pending_ops.size(), it);
    endfunction

    function automatic logic [DATA_W-1:0] random_value();
        case ($urandom_range(0, 11))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom();
        endcase
    endfunction

    // sample both handshakes, predict on input beats, check result beats
    always @(posedge aclk) begin
        deque_result_t want;
        in_taken  = aresetn && s_tvalid && s_tready;
        out_taken = aresetn && m_tvalid && m_tready;
        if (in_taken)
            expected_results.insert(expected_results.size(),
                                    deque_apply(dq_op_t'(s_tuser), s_tdata));
        if (out_taken) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                $display("%0t: result beat with nothing expected: status %0d value %h occ %0d",
                         $time, m_tuser, m_tdata[31:0], m_tdata[36:32]);
                mismatches++;
            end else begin
                want = expected_results[0];
                expected_results.delete(0);
                if (m_tuser !== want.status) begin
                    $display("%0t: status expected %0d, actual %0d",
                             $time, want.status, m_tuser);
                    mismatches++;
                end
                if (m_tdata[31:0] !== want.removed) begin
                    $display("%0t: removed_value expected %h, actual %h",
                             $time, want.removed, m_tdata[31:0]);
                    mismatches++;
                end
                if (m_tdata[36:32] !== want.occupancy) begin
                    $display("%0t: occupancy expected %0d, actual %0d",
                             $time, want.occupancy, m_tdata[36:32]);
                    mismatches++;
                end
            end
        end
    end

    // input driver
    deque_op_t tx_item = '{OP_PUSH_FRONT, '0};
    bit        tx_busy = 1'b0;
    int        tx_gap  = 0;

    always @(negedge aclk) begin
        if (aresetn) begin
            if (in_taken) begin
                tx_busy = 1'b0;
                tx_gap  = draw_idle(SIDE_TX);
            end
            if (!tx_busy) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (pending_ops.size() > 0) begin
                    tx_item = pending_ops[0];
                    pending_ops.delete(0);
                    tx_busy = 1'b1;
                end
            end
            s_tvalid <= tx_busy;
            s_tdata  <= tx_item.value;
            s_tuser  <= tx_item.op;
        end
    end

    // result receiver, with one long hold-off to back the block up
    int rx_wait   = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    always @(negedge aclk) begin
        if (aresetn) begin
            if (out_taken)
                rx_wait = draw_idle(SIDE_RX);
            if (!hold_done && results_seen >= HOLD_AFTER) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycles);
            $display("** double_ended_queue: FAILED **");
            $finish;
        end
    end

    // stimulus and end of run
    initial begin
        int    n;
        int    seg_len;
        int    push_pct;
        dq_op_t op;

        // directed: empty pops, extreme values at both ends, wrap of the front pointer
        add_op(OP_POP_FRONT,  32'h1234_5678);
        add_op(OP_POP_BACK,   32'hffff_ffff);
        add_op(OP_PUSH_FRONT, 32'h7fff_ffff);
        add_op(OP_PUSH_BACK,  32'h8000_0000);
        add_op(OP_PUSH_FRONT, 32'h0000_0000);
        add_op(OP_PUSH_BACK,  32'hffff_ffff);
        add_op(OP_PUSH_FRONT, 32'h5555_5555);
        add_op(OP_PUSH_BACK,  32'haaaa_aaaa);
        add_op(OP_POP_BACK,   32'h0);
        add_op(OP_POP_FRONT,  32'h0);
        add_op(OP_POP_BACK,   32'h0);
        add_op(OP_POP_FRONT,  32'h0);
        add_op(OP_POP_FRONT,  32'h0);
        add_op(OP_POP_BACK,   32'h0);
        add_op(OP_POP_FRONT,  32'hdead_beef);
        add_op(OP_PUSH_BACK,  32'h0000_0001);
        add_op(OP_POP_FRONT,  32'h0);

        // random: segments leaning to fill, drain or churn so both full and empty recur
        n = 0;
        while (n < ITEM_COUNT) begin
            seg_len = $urandom_range(15, 60);
            case ($urandom_range(0, 2))
                0:       push_pct = 90;
                1:       push_pct = 50;
                default: push_pct = 12;
            endcase
            repeat (seg_len) begin
                if ($urandom_range(0, 99) < push_pct)
                    op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
                else
                    op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
                add_op(op, random_value());
                n++;
            end
        end

        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        while (pending_ops.size() > 0 || tx_busy || expected_results.size() > 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("** double_ended_queue: PASSED **");
        end else begin
            $display("** double_ended_queue: FAILED **");
        end
        $finish;
    end

endmodule
